// ===== hdl/ssb_pkg.sv =====
// Shared definitions for the seven-segment scan and blink driver.
// Opcodes, the BCD segment table and the dot bank control bundle; no dependencies.
`default_nettype none

package ssb_pkg;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_CLEAR     = 3'd1,
		OP_WRITE     = 3'd2,
		OP_SET_DOT   = 3'd3,
		OP_FLASH_RNG = 3'd4,
		OP_FLASH_DOT = 3'd5
	} op_t;

	localparam int SEG_W      = 8;
	localparam int DOT_POS    = 7;
	localparam logic [3:0] NDIG_RESET = 4'd8;

	typedef struct packed {
		logic frame;	// scan wrapped to digit 0 on a tick
		logic load;	// flash-dot command taken with an in-range position
	} dot_ctrl_t;

	function automatic logic [SEG_W-1:0] bcd_seg(input logic [3:0] bcd);
		logic [SEG_W-1:0] s;
		unique case (bcd)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ssb_dot_bank.sv =====
// Per-digit dot blink periods and counters for the scan and blink driver.
// Depends on ssb_pkg (dot_ctrl_t).
`default_nettype none

module ssb_dot_bank #(
	parameter int MAX_DIGITS  = 8,
	parameter int PERIOD_BITS = 16,
	parameter int IDX_W       = 3,
	parameter int CW          = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  ssb_pkg::dot_ctrl_t     ctrl,
	input  wire  [CW-1:0]          ndig,
	input  wire  [IDX_W-1:0]       ld_idx,
	input  wire  [PERIOD_BITS-1:0] ld_period,
	input  wire  [IDX_W-1:0]       rd_idx,
	output logic                   blank
);
	import ssb_pkg::*;

	logic [PERIOD_BITS-1:0] per_q   [MAX_DIGITS];
	logic [PERIOD_BITS-1:0] cnt_q   [MAX_DIGITS];
	logic [PERIOD_BITS-1:0] cnt_upd [MAX_DIGITS];

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cnt
		localparam logic [CW-1:0] I_CW = CW'(i);
		always_comb begin
			cnt_upd[i] = cnt_q[i];
			if (ctrl.frame && (I_CW < ndig) && (per_q[i] != '0)) begin
				if (cnt_q[i] < per_q[i] - PERIOD_BITS'(1))
					cnt_upd[i] = cnt_q[i] + PERIOD_BITS'(1);
				else
					cnt_upd[i] = '0;
			end
		end
	end

	assign blank = (per_q[rd_idx] != '0) && (cnt_upd[rd_idx] < (per_q[rd_idx] >> 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				per_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (ctrl.frame) begin
			for (int i = 0; i < MAX_DIGITS; i++)
				cnt_q[i] <= cnt_upd[i];
		end else if (ctrl.load && (per_q[ld_idx] != ld_period)) begin
			per_q[ld_idx] <= ld_period;
			cnt_q[ld_idx] <= '0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/seven_segment_scan_blink.sv =====
// Multiplexed seven-segment driver with digit-range and per-dot blinking.
// Each item is registered first in the input reg and then in the result reg before its result transfer.
// Throughput: one item per cycle; stalls only when the result reg is held.
// Reset (arst_n low, async): video store, scan, blink state cleared,
// digit count set to 8. Depends on ssb_pkg and ssb_dot_bank.
`default_nettype none

module seven_segment_scan_blink #(
	parameter int MAX_DIGITS  = 8,
	parameter int PERIOD_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [3:0]  cfg_wdata,	// number_of_digits
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[2:0] digit_position[5:3] bcd_value[9:6] dot_on[10]
	// range_from[14:11] range_to[18:15] half_frames[33:19], zero pad
	input  wire  [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// digit_select[2:0] segment_pattern[10:3] status[11], zero pad
	output logic [15:0] m_axis_tdata
);
	import ssb_pkg::*;

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int CW    = (CNT_W > 4) ? CNT_W : 4;
	localparam logic [CW-1:0] MAX_CW = CW'(MAX_DIGITS);
	localparam logic [CW-1:0] ONE_CW = CW'(1);

	// config
	logic [3:0] ndig_cfg_q;

	// input stage
	logic                   valid_s1;
	logic [2:0]             op_s1;
	logic [2:0]             pos_s1;
	logic [3:0]             bcd_s1;
	logic                   dot_s1;
	logic [3:0]             from_s1;
	logic [3:0]             to_s1;
	logic [14:0]            half_s1;

	// result stage
	logic                   valid_s2;
	logic [2:0]             dsel_s2;
	logic [SEG_W-1:0]       seg_s2;
	logic                   stat_s2;

	// block state
	logic [SEG_W-1:0]       vs_q [MAX_DIGITS];
	logic [IDX_W-1:0]       scan_q;
	logic [IDX_W-1:0]       bfirst_q;
	logic [IDX_W-1:0]       blast_q;
	logic [PERIOD_BITS-1:0] bper_q;
	logic [PERIOD_BITS-1:0] bcnt_q;

	logic adv, fire, s_fire;
	op_t  op;

	assign adv           = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && adv;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign op            = op_t'(op_s1);

	// digit count, scan and index arithmetic
	logic [CW-1:0]          cfg_cw, ndig, nm1, pos_cw, scan_cw, scan_nx_cw, sd_pos, rev_cw;
	logic [CW-1:0]          from_cw, to_cw, bfirst_cw, blast_cw;
	logic [IDX_W-1:0]       scan_nx, pos_idx, rev_idx;
	logic                   wrap;
	logic [PERIOD_BITS+15:0] period_w;
	logic [PERIOD_BITS-1:0] period;
	logic [PERIOD_BITS-1:0] bcnt_inc, bcnt_nx;
	logic [SEG_W-1:0]       seg_tick, seg_res;
	logic                   stat_res, rng_bad, rng_same, pos_bad, dot_blank;
	dot_ctrl_t              dctl;

	always_comb begin
		cfg_cw = CW'(ndig_cfg_q);
		if (cfg_cw == '0)
			ndig = ONE_CW;
		else if (cfg_cw > MAX_CW)
			ndig = MAX_CW;
		else
			ndig = cfg_cw;
		nm1        = ndig - ONE_CW;
		pos_cw     = CW'(pos_s1);
		pos_idx    = pos_cw[IDX_W-1:0];
		scan_cw    = CW'(scan_q);
		scan_nx_cw = (scan_cw < nm1) ? scan_cw + ONE_CW : '0;
		scan_nx    = scan_nx_cw[IDX_W-1:0];
		wrap       = (scan_nx_cw == '0);
		pos_bad    = (pos_cw >= ndig);
		sd_pos     = pos_bad ? nm1 : pos_cw;
		rev_cw     = nm1 - sd_pos;
		rev_idx    = rev_cw[IDX_W-1:0];
		period_w   = {{PERIOD_BITS{1'b0}}, half_s1, 1'b0};
		period     = period_w[PERIOD_BITS-1:0];
		from_cw    = CW'(from_s1);
		to_cw      = CW'(to_s1);
		bfirst_cw  = CW'(bfirst_q);
		blast_cw   = CW'(blast_q);
		rng_bad    = (from_cw > to_cw) || (from_cw >= MAX_CW) || (to_cw >= MAX_CW);
		rng_same   = (bfirst_cw == from_cw) && (blast_cw == to_cw) && (bper_q == period);
	end

	// tick: blink counter and displayed byte
	always_comb begin
		bcnt_inc = bcnt_q + PERIOD_BITS'(1);
		bcnt_nx  = bcnt_q;
		if (bper_q != '0 && wrap)
			bcnt_nx = (bcnt_inc == bper_q) ? '0 : bcnt_inc;
		seg_tick = vs_q[scan_nx];
		if (bper_q != '0 && bcnt_nx < (bper_q >> 1) &&
				scan_nx_cw >= bfirst_cw && scan_nx_cw <= blast_cw)
			seg_tick = seg_tick & (SEG_W'(1) << DOT_POS);
		if (dot_blank)
			seg_tick[DOT_POS] = 1'b0;
	end

	always_comb begin
		seg_res    = '0;
		stat_res   = 1'b0;
		dctl.frame = 1'b0;
		dctl.load  = 1'b0;
		unique case (op)
			OP_TICK: begin
				seg_res    = seg_tick;
				dctl.frame = fire && wrap;
			end
			OP_FLASH_RNG: stat_res = rng_bad;
			OP_FLASH_DOT: begin
				stat_res  = pos_bad;
				dctl.load = fire && !pos_bad;
			end
			default: ;
		endcase
	end

	ssb_dot_bank #(
		.MAX_DIGITS (MAX_DIGITS),
		.PERIOD_BITS(PERIOD_BITS),
		.IDX_W      (IDX_W),
		.CW         (CW)
	) u_dots (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (dctl),
		.ndig     (ndig),
		.ld_idx   (rev_idx),
		.ld_period(period),
		.rd_idx   (scan_nx),
		.blank    (dot_blank)
	);

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++)
				vs_q[i] <= '0;
			scan_q   <= '0;
			bfirst_q <= '0;
			blast_q  <= '0;
			bper_q   <= '0;
			bcnt_q   <= '0;
		end else if (fire) begin
			unique case (op)
				OP_TICK: begin
					scan_q <= scan_nx;
					bcnt_q <= bcnt_nx;
				end
				OP_CLEAR: begin
					for (int i = 0; i < MAX_DIGITS; i++)
						if (CW'(i) < ndig)
							vs_q[i][DOT_POS-1:0] <= '0;
				end
				OP_WRITE: begin
					if (!pos_bad)
						vs_q[pos_idx] <= bcd_seg(bcd_s1);
				end
				OP_SET_DOT: vs_q[rev_idx][DOT_POS] <= dot_s1;
				OP_FLASH_RNG: begin
					if (!rng_bad && !rng_same) begin
						bfirst_q <= from_cw[IDX_W-1:0];
						blast_q  <= to_cw[IDX_W-1:0];
						bper_q   <= period;
						bcnt_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// config register and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_cfg_q <= NDIG_RESET;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (cfg_we)
				ndig_cfg_q <= cfg_wdata;
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1   <= s_axis_tdata[2:0];
			pos_s1  <= s_axis_tdata[5:3];
			bcd_s1  <= s_axis_tdata[9:6];
			dot_s1  <= s_axis_tdata[10];
			from_s1 <= s_axis_tdata[14:11];
			to_s1   <= s_axis_tdata[18:15];
			half_s1 <= s_axis_tdata[33:19];
		end
		if (fire) begin
			dsel_s2 <= (op == OP_TICK) ? scan_nx_cw[2:0] : scan_cw[2:0];
			seg_s2  <= seg_res;
			stat_s2 <= stat_res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0, stat_s2, seg_s2, dsel_s2};

`ifndef NO_ASSERTIONS
	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bper_q != '0 |-> bcnt_q < bper_q)
		else $error("blink counter outside its period");

	a_stat_no_seg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && stat_s2 |-> seg_s2 == '0)
		else $error("rejected command carries a segment pattern");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(op_s1) && $stable(half_s1))
		else $error("held input item lost or changed");

	a_rng_order: assert property (@(posedge clk) disable iff (!arst_n)
		bper_q != '0 |-> bfirst_q <= blast_q)
		else $error("blink range stored out of order");
`endif

endmodule

`default_nettype wire

// ===== sim/seven_segment_scan_blink_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for seven_segment_scan_blink: directed and random command streams
// against a cycle-free display predictor. Depends on ssb_pkg and the block's RTL.

module seven_segment_scan_blink_tb;
	import ssb_pkg::*;

	localparam int DIGITS_MAX = 8;
	localparam logic [2:0] OP_RSVD_A = 3'd6;
	localparam logic [2:0] OP_RSVD_B = 3'd7;
	localparam int ITEMS_PER_PHASE = 150;

	localparam logic [7:0] SEG_OF_BCD [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	typedef struct packed {
		logic [14:0] half_frames;
		logic [3:0]  range_to;
		logic [3:0]  range_from;
		logic        dot_on;
		logic [3:0]  bcd_value;
		logic [2:0]  digit_position;
		logic [2:0]  opcode;
	} cmd_t;

	typedef struct packed {
		logic       status;
		logic [7:0] segment_pattern;
		logic [2:0] digit_select;
	} readout_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [15:0] m_axis_tdata;

	// display state as predicted
	logic [3:0]  disp_count;
	logic [7:0]  disp_store [DIGITS_MAX];
	logic [2:0]  disp_scan;
	logic [2:0]  rng_first, rng_last;
	logic [15:0] rng_period, rng_count;
	logic [15:0] dot_per [DIGITS_MAX];
	logic [15:0] dot_cnt [DIGITS_MAX];

	readout_t expected_readout [$];
	int       mismatch_count = 0;
	bit       steady = 1'b0;

	seven_segment_scan_blink #(
		.MAX_DIGITS (DIGITS_MAX),
		.PERIOD_BITS(16)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic int digits_used();
		if (disp_count == 4'd0) return 1;
		if (disp_count > DIGITS_MAX) return DIGITS_MAX;
		return int'(disp_count);
	endfunction

	function automatic readout_t display_step(input cmd_t c);
		readout_t r;
		int n, k;
		logic [7:0] seg;
		logic [15:0] per;
		logic stat;
		n = digits_used();
		seg = '0;
		stat = 1'b0;
		per = {c.half_frames, 1'b0};
		case (c.opcode)
			OP_TICK: begin
				if (int'(disp_scan) < n - 1) disp_scan = disp_scan + 3'd1;
				else disp_scan = '0;
				seg = disp_store[disp_scan];
				if (rng_period != 0) begin
					if (disp_scan == 0) rng_count = (rng_count + 16'd1) % rng_period;
					if (rng_count < rng_period / 2 && disp_scan >= rng_first &&
					    disp_scan <= rng_last)
						seg = {seg[DOT_POS], 7'b0};
				end
				if (disp_scan == 0) begin
					for (k = 0; k < n; k++) begin
						if (dot_per[k] != 0) begin
							if (dot_cnt[k] < dot_per[k] - 16'd1) dot_cnt[k] = dot_cnt[k] + 16'd1;
							else dot_cnt[k] = '0;
						end
					end
				end
				if (dot_per[disp_scan] != 0 && dot_cnt[disp_scan] < dot_per[disp_scan] / 2)
					seg[DOT_POS] = 1'b0;
			end
			OP_CLEAR: begin
				for (k = 0; k < n; k++) disp_store[k] = {disp_store[k][DOT_POS], 7'b0};
			end
			OP_WRITE: begin
				if (int'(c.digit_position) < n)
					disp_store[c.digit_position] = (c.bcd_value < 10) ? SEG_OF_BCD[c.bcd_value] : '0;
			end
			OP_SET_DOT: begin
				k = int'(c.digit_position);
				if (k >= n) k = n - 1;
				k = n - 1 - k;
				disp_store[k][DOT_POS] = c.dot_on;
			end
			OP_FLASH_RNG: begin
				if (c.range_from > c.range_to || c.range_from >= DIGITS_MAX ||
				    c.range_to >= DIGITS_MAX) begin
					stat = 1'b1;
				end else if (rng_first != c.range_from[2:0] || rng_last != c.range_to[2:0] ||
				             rng_period != per) begin
					rng_first = c.range_from[2:0];
					rng_last = c.range_to[2:0];
					rng_period = per;
					rng_count = '0;
				end
			end
			OP_FLASH_DOT: begin
				if (int'(c.digit_position) >= n) begin
					stat = 1'b1;
				end else begin
					k = n - 1 - int'(c.digit_position);
					if (dot_per[k] != per) begin
						dot_per[k] = per;
						dot_cnt[k] = '0;
					end
				end
			end
			default: ;
		endcase
		r.digit_select = disp_scan;
		r.segment_pattern = seg;
		r.status = stat;
		return r;
	endfunction

	function automatic cmd_t cmd(input logic [2:0] op, input logic [2:0] pos,
	                             input logic [3:0] bcd, input logic dot,
	                             input logic [3:0] from, input logic [3:0] to,
	                             input logic [14:0] half);
		cmd_t c;
		c.opcode = op;
		c.digit_position = pos;
		c.bcd_value = bcd;
		c.dot_on = dot;
		c.range_from = from;
		c.range_to = to;
		c.half_frames = half;
		return c;
	endfunction

	function automatic logic [14:0] blink_half();
		if ($urandom_range(0, 9) == 0) return 15'($urandom_range(0, 32767));
		return 15'($urandom_range(0, 3));
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		logic [63:0] raw;
		int n, r;
		raw = {$urandom(), $urandom()};
		c = raw[33:0];
		n = digits_used();
		r = $urandom_range(0, 99);
		if (r < 55) begin
			c.opcode = OP_TICK;
		end else if (r < 64) begin
			c.opcode = OP_WRITE;
		end else if (r < 71) begin
			c.opcode = OP_SET_DOT;
			if ($urandom_range(0, 3) != 0) c.digit_position = 3'($urandom_range(0, n - 1));
		end else if (r < 74) begin
			c.opcode = OP_CLEAR;
		end else if (r < 83) begin
			c.opcode = OP_FLASH_RNG;
			if ($urandom_range(0, 4) != 0) begin
				c.range_to = 4'($urandom_range(0, DIGITS_MAX - 1));
				c.range_from = 4'($urandom_range(0, c.range_to));
			end
			c.half_frames = blink_half();
			if ($urandom_range(0, 9) == 0) begin
				c.range_from = {1'b0, rng_first};
				c.range_to = {1'b0, rng_last};
				c.half_frames = rng_period[15:1];
			end
		end else if (r < 93) begin
			c.opcode = OP_FLASH_DOT;
			if ($urandom_range(0, 4) != 0) c.digit_position = 3'($urandom_range(0, n - 1));
			c.half_frames = blink_half();
			if (int'(c.digit_position) < n && $urandom_range(0, 7) == 0)
				c.half_frames = dot_per[n - 1 - int'(c.digit_position)][15:1];
		end else if (r < 97) begin
			c.opcode = $urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B;
		end
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send(input cmd_t c);
		while (!steady && $urandom_range(0, 99) < 37) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, c};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_readout.push_back(display_step(c));
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (expected_readout.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_digits(input logic [3:0] v);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		disp_count = v;
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		readout_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[11:0];
			if (expected_readout.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer %h", m_axis_tdata));
			end else begin
				want = expected_readout.pop_front();
				if (got.digit_select !== want.digit_select)
					report_mismatch($sformatf("digit_select %0d, want %0d",
						got.digit_select, want.digit_select));
				if (got.segment_pattern !== want.segment_pattern)
					report_mismatch($sformatf("segment_pattern %h, want %h",
						got.segment_pattern, want.segment_pattern));
				if (got.status !== want.status)
					report_mismatch($sformatf("status %b, want %b", got.status, want.status));
			end
		end
		m_axis_tready <= arst_n && (steady || $urandom_range(0, 99) >= 37);
	end

	task automatic test_write_decode();
		send(cmd(OP_TICK, 3'd0, 4'd0, 1'b0, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_WRITE, 3'd0, 4'd8, 1'b0, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_WRITE, 3'd7, 4'd15, 1'b1, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_WRITE, 3'd3, 4'd9, 1'b0, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_WRITE, 3'd1, 4'd10, 1'b0, 4'd0, 4'd0, 15'd0));
		repeat (DIGITS_MAX) send(cmd(OP_TICK, 3'd0, 4'd0, 1'b0, 4'd0, 4'd0, 15'd0));
	endtask

	task automatic test_dots_and_clear();
		send(cmd(OP_SET_DOT, 3'd0, 4'd0, 1'b1, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_SET_DOT, 3'd7, 4'd0, 1'b1, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_CLEAR, 3'd0, 4'd0, 1'b0, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_WRITE, 3'd0, 4'd3, 1'b0, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_SET_DOT, 3'd0, 4'd0, 1'b0, 4'd0, 4'd0, 15'd0));
	endtask

	task automatic test_flash();
		send(cmd(OP_FLASH_RNG, 3'd0, 4'd0, 1'b0, 4'd5, 4'd2, 15'd1));
		send(cmd(OP_FLASH_RNG, 3'd0, 4'd0, 1'b0, 4'd8, 4'd15, 15'd1));
		send(cmd(OP_FLASH_RNG, 3'd0, 4'd0, 1'b0, 4'd0, 4'd7, 15'd1));
		send(cmd(OP_FLASH_RNG, 3'd0, 4'd0, 1'b0, 4'd0, 4'd7, 15'd1));
		send(cmd(OP_FLASH_DOT, 3'd0, 4'd0, 1'b0, 4'd0, 4'd0, 15'd1));
		send(cmd(OP_FLASH_DOT, 3'd7, 4'd0, 1'b0, 4'd0, 4'd0, 15'h7FFF));
		send(cmd(OP_RSVD_A, 3'd7, 4'hF, 1'b1, 4'hF, 4'hF, 15'h7FFF));
		send(cmd(OP_RSVD_B, 3'd7, 4'hF, 1'b1, 4'hF, 4'hF, 15'h7FFF));
	endtask

	task automatic test_digit_count();
		while (disp_scan != 3'd7) send(cmd(OP_TICK, 3'd0, 4'd0, 1'b0, 4'd0, 4'd0, 15'd0));
		set_digits(4'd3);
		send(cmd(OP_TICK, 3'd0, 4'd0, 1'b0, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_WRITE, 3'd5, 4'd4, 1'b0, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_SET_DOT, 3'd7, 4'd0, 1'b1, 4'd0, 4'd0, 15'd0));
		send(cmd(OP_FLASH_DOT, 3'd5, 4'd0, 1'b0, 4'd0, 4'd0, 15'd2));
		set_digits(4'd0);
		repeat (2) send(cmd(OP_TICK, 3'd0, 4'd0, 1'b0, 4'd0, 4'd0, 15'd0));
		set_digits(4'd15);
		send(cmd(OP_TICK, 3'd0, 4'd0, 1'b0, 4'd0, 4'd0, 15'd0));
	endtask

	task automatic test_random();
		logic [3:0] counts [13] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2,
		                            4'd7, 4'd9, 4'd4, 4'd6, 4'd8, 4'd1};
		int p;
		for (p = 0; p < 13; p++) begin
			set_digits(counts[p]);
			steady = (p == 7);
			repeat (ITEMS_PER_PHASE) send(random_cmd());
		end
		steady = 1'b0;
	endtask

	initial begin
		disp_count = NDIG_RESET;
		disp_scan = '0;
		rng_first = '0;
		rng_last = '0;
		rng_period = '0;
		rng_count = '0;
		for (int k = 0; k < DIGITS_MAX; k++) begin
			disp_store[k] = '0;
			dot_per[k] = '0;
			dot_cnt[k] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_write_decode();
		test_dots_and_clear();
		test_flash();
		test_digit_count();
		test_random();
		wait_for_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_readout.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ssb_pkg.sv
hdl/ssb_dot_bank.sv
hdl/seven_segment_scan_blink.sv
sim/seven_segment_scan_blink_tb.sv
